// ===== rtl/b64d_pkg.sv =====
// shared types, codes and character functions of the base64 stream decoder
package b64d_pkg;

	localparam logic       KIND_DATA   = 1'b0;
	localparam logic       KIND_STATUS = 1'b1;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_LEN = 2'd2;
	localparam logic [1:0] ST_CAP = 2'd3;

	localparam logic [7:0]  PAD_CHAR     = 8'h3D;
	localparam logic [16:0] CAP_RESET    = 17'h10000;
	localparam int          CAP_WIDTH    = 17;
	localparam int          OUT_TDATA_W  = 32;

	typedef struct packed {
		logic       present;
		logic [7:0] ch;
		logic       last;
	} b64d_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  out_byte;
		logic [1:0]  status;
		logic [15:0] byte_count;
		logic        last;
	} b64d_res_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// {valid, sextet}
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
			return {1'b1, d[5:0]};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h61 + 8'd26;
			return {1'b1, d[5:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30 + 8'd52;
			return {1'b1, d[5:0]};
		end else if (c == 8'h2B) begin
			return {1'b1, 6'd62};
		end else if (c == 8'h2F) begin
			return {1'b1, 6'd63};
		end
		return 7'd0;
	endfunction

endpackage

// ===== rtl/b64d_core.sv =====
// per-message decode state, one character per cycle while go is set, up to two results per word
module b64d_core #(
	parameter int LEN_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  b64d_pkg::b64d_item_t           item,
	input  logic [b64d_pkg::CAP_WIDTH-1:0] capacity,
	output logic                           res0_valid,
	output b64d_pkg::b64d_res_t            res0,
	output logic                           res1_valid,
	output b64d_pkg::b64d_res_t            res1
);
	import b64d_pkg::*;

	localparam int CW = (LEN_WIDTH + 2 > CAP_WIDTH + 1) ? LEN_WIDTH + 2 : CAP_WIDTH + 1;
	localparam int BW = (LEN_WIDTH > 16) ? LEN_WIDTH : 16;

	logic [1:0]           pos_q, nx_pos;
	logic [5:0]           held_q, nx_held;
	logic                 pad_q, nx_pad;
	logic                 fin_q, nx_fin;
	logic                 err_q, nx_err;
	logic                 started_q, nx_started;
	logic [LEN_WIDTH-1:0] blank_q, nx_blank;
	logic [LEN_WIDTH-1:0] len_q, nx_len;
	logic [LEN_WIDTH-1:0] bytes_q, nx_bytes;

	logic                 blank;
	logic [6:0]           sx;
	logic                 sx_ok;
	logic [5:0]           v;
	logic                 active;
	logic [LEN_WIDTH:0]   sum;
	logic                 emit;
	logic [7:0]           dbyte;
	logic [CW-1:0]        quarter;
	logic [CW-1:0]        need;
	logic                 short_cap;
	logic [1:0]           st;
	logic [BW-1:0]        cnt_ext;

	always_comb begin
		nx_pos     = pos_q;
		nx_held    = held_q;
		nx_pad     = pad_q;
		nx_fin     = fin_q;
		nx_err     = err_q;
		nx_started = started_q;
		nx_blank   = blank_q;
		nx_len     = len_q;
		nx_bytes   = bytes_q;
		blank      = is_blank(item.ch);
		sx         = sextet_of(item.ch);
		sx_ok      = sx[6];
		v          = sx[5:0];
		active     = 1'b0;
		sum        = '0;
		emit       = 1'b0;
		dbyte      = '0;
		if (item.present) begin
			if (blank) begin
				if (started_q && blank_q != '1) begin
					nx_blank = blank_q + 1'b1;
				end
			end else begin
				active = !fin_q && !err_q;
				if (!started_q) begin
					nx_started = 1'b1;
					nx_len     = LEN_WIDTH'(1);
				end else begin
					sum    = {1'b0, len_q} + {1'b0, blank_q} + (LEN_WIDTH+1)'(1);
					nx_len = sum[LEN_WIDTH] ? '1 : sum[LEN_WIDTH-1:0];
				end
				if (active && blank_q != '0) begin
					nx_err = 1'b1;
					active = 1'b0;
				end
				nx_blank = '0;
				if (active) begin
					unique case (pos_q)
						2'd0: begin
							if (!sx_ok) begin
								nx_err = 1'b1;
							end else begin
								nx_held = v;
								nx_pos  = 2'd1;
							end
						end
						2'd1: begin
							if (!sx_ok) begin
								nx_err = 1'b1;
							end else begin
								emit    = 1'b1;
								dbyte   = {held_q, v[5:4]};
								nx_held = v;
								nx_pos  = 2'd2;
							end
						end
						2'd2: begin
							if (item.ch == PAD_CHAR) begin
								nx_pad = 1'b1;
								nx_pos = 2'd3;
							end else if (!sx_ok) begin
								nx_err = 1'b1;
							end else begin
								emit    = 1'b1;
								dbyte   = {held_q[3:0], v[5:2]};
								nx_held = v;
								nx_pos  = 2'd3;
							end
						end
						default: begin
							if (pad_q) begin
								if (item.ch == PAD_CHAR) begin
									nx_fin = 1'b1;
								end else begin
									nx_err = 1'b1;
								end
							end else if (item.ch == PAD_CHAR) begin
								nx_fin = 1'b1;
							end else if (!sx_ok) begin
								nx_err = 1'b1;
							end else begin
								emit   = 1'b1;
								dbyte  = {held_q[1:0], v};
								nx_pos = 2'd0;
							end
						end
					endcase
					if (emit && bytes_q != '1) begin
						nx_bytes = bytes_q + 1'b1;
					end
				end
			end
		end
	end

	// end of message status from the updated state
	always_comb begin
		quarter   = CW'(nx_len >> 2);
		need      = (quarter << 1) + quarter + CW'(1);
		short_cap = need > CW'(capacity);
		cnt_ext   = BW'(nx_bytes);
		priority if (nx_len[1:0] != 2'd0) begin
			st = ST_LEN;
		end else if (short_cap) begin
			st = ST_CAP;
		end else if (nx_err) begin
			st = ST_BAD;
		end else begin
			st = ST_OK;
		end
	end

	always_comb begin
		res0_valid      = go && emit;
		res0.kind       = KIND_DATA;
		res0.out_byte   = dbyte;
		res0.status     = ST_OK;
		res0.byte_count = '0;
		res0.last       = 1'b0;
		res1_valid      = go && item.last;
		res1.kind       = KIND_STATUS;
		res1.out_byte   = '0;
		res1.status     = st;
		res1.byte_count = (st == ST_OK) ? cnt_ext[15:0] : 16'd0;
		res1.last       = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			held_q    <= '0;
			pad_q     <= 1'b0;
			fin_q     <= 1'b0;
			err_q     <= 1'b0;
			started_q <= 1'b0;
			blank_q   <= '0;
			len_q     <= '0;
			bytes_q   <= '0;
		end else if (go) begin
			if (item.last) begin
				pos_q     <= '0;
				held_q    <= '0;
				pad_q     <= 1'b0;
				fin_q     <= 1'b0;
				err_q     <= 1'b0;
				started_q <= 1'b0;
				blank_q   <= '0;
				len_q     <= '0;
				bytes_q   <= '0;
			end else begin
				pos_q     <= nx_pos;
				held_q    <= nx_held;
				pad_q     <= nx_pad;
				fin_q     <= nx_fin;
				err_q     <= nx_err;
				started_q <= nx_started;
				blank_q   <= nx_blank;
				len_q     <= nx_len;
				bytes_q   <= nx_bytes;
			end
		end
	end

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		go && item.last |=> !started_q && len_q == '0 && bytes_q == '0)
		else $error("message state not cleared after end of message");
	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> $stable(pos_q) && $stable(len_q) && $stable(bytes_q))
		else $error("decode state moved without a word");
	a_no_byte_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		res0_valid |-> !fin_q && !err_q)
		else $error("byte emitted after padding or error");
`endif

endmodule

// ===== rtl/base64_stream_decoder.sv =====
// top level: input register, decode core and result queue of the base64 stream decoder
// a taken word waits in the input register until the queue has room; its results then enter the result queue
// throughput: one character per cycle while the four-entry result queue holds two or fewer
// a character that also ends the message can give two results, a data byte and then the status
// reset: clears the message state and the queue, out_capacity returns to 65536
module base64_stream_decoder #(
	parameter int LEN_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // in_char
	input  logic                           s_tuser,   // present
	input  logic                           s_tlast,   // is_last
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [b64d_pkg::OUT_TDATA_W-1:0] m_tdata, // out_byte, status, byte_count
	output logic                           m_tuser,   // kind
	output logic                           m_tlast,   // last_of_run
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [b64d_pkg::CAP_WIDTH-1:0] cfg_data   // out_capacity
);
	import b64d_pkg::*;

	localparam int QD = 4;

	logic                 s1_valid;
	b64d_item_t           item_s1;
	logic [CAP_WIDTH-1:0] cap_q;
	logic                 adv;
	logic                 r0v, r1v;
	b64d_res_t            r0, r1;
	b64d_res_t            que_q [QD];
	b64d_res_t            que_nx [QD];
	logic [2:0]           cnt_q;
	logic [2:0]           base;
	logic [2:0]           cnt_nx;
	logic                 pop;

	assign cfg_ready = 1'b1;
	assign adv       = s1_valid && (cnt_q <= 3'd2);
	assign s_tready  = !s1_valid || adv;
	assign pop       = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.present <= s_tuser;
			item_s1.ch      <= s_tdata;
			item_s1.last    <= s_tlast;
		end
	end

	b64d_core #(
		.LEN_WIDTH(LEN_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (adv),
		.item      (item_s1),
		.capacity  (cap_q),
		.res0_valid(r0v),
		.res0      (r0),
		.res1_valid(r1v),
		.res1      (r1)
	);

	// shift queue: head always in entry zero
	always_comb begin
		base   = cnt_q - {2'b0, pop};
		cnt_nx = base + {2'b0, r0v} + {2'b0, r1v};
		for (int i = 0; i < QD; i++) begin
			if (pop && i < QD - 1) begin
				que_nx[i] = que_q[i + 1];
			end else begin
				que_nx[i] = que_q[i];
			end
			if (r0v && base == 3'(i)) begin
				que_nx[i] = r0;
			end
			if (r1v && (base + {2'b0, r0v}) == 3'(i)) begin
				que_nx[i] = r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QD; i++) begin
			que_q[i] <= que_nx[i];
		end
	end

	assign m_tvalid = cnt_q != 3'd0;
	assign m_tuser  = que_q[0].kind;
	assign m_tlast  = que_q[0].last;
	assign m_tdata  = {6'b0, que_q[0].byte_count, que_q[0].status, que_q[0].out_byte};

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(QD))
		else $error("result queue overflow");
	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (que_q[0].kind == KIND_STATUS) == que_q[0].last)
		else $error("last flag does not match result kind");
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && que_q[0].kind == KIND_DATA |->
			que_q[0].status == ST_OK && que_q[0].byte_count == 16'd0)
		else $error("data word carries status fields");
	a_stall_keeps_item: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !adv |=> s1_valid)
		else $error("stalled word dropped");
`endif

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench of base64_stream_decoder: random and directed base64 text against a decoder model
module tb_top;
	import b64d_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 9;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_WORDS   = 125;
	localparam int LIMIT_CYCLES  = 600000;

	localparam int IDLE_NONE     = 0;
	localparam int IDLE_SENDER   = 1;
	localparam int IDLE_RECEIVER = 2;
	localparam int IDLE_BOTH     = 3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = 8'h00;
	logic                 s_tuser = 1'b0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CAP_WIDTH-1:0] cfg_data = '0;

	base64_stream_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	b64d_item_t text_words[$];
	b64d_res_t  due_results[$];
	b64d_item_t cur_word;
	logic       word_taken = 1'b0;
	int         idle_mode = IDLE_NONE;
	logic       hold_go = 1'b0;
	int         hold_cnt = 0;
	int         errors = 0;
	int         planned_words = 0;
	int         bytes_seen = 0;
	int         status_seen[4] = '{0, 0, 0, 0};

	// decoder model state
	logic [16:0] capacity = CAP_RESET;
	logic [1:0]  quad_pos = '0;
	logic [5:0]  held = '0;
	logic        pad_seen = 1'b0;
	logic        pad_done = 1'b0;
	logic        bad_seen = 1'b0;
	logic        text_started = 1'b0;
	logic [15:0] blank_len = '0;
	logic [15:0] text_len = '0;
	logic [15:0] byte_total = '0;

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	function automatic logic blank_char(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// alphabet value, or -1 outside the alphabet
	function automatic int alpha_value(input logic [7:0] c);
		if (c inside {[8'h41:8'h5A]}) return int'(c) - 65;
		if (c inside {[8'h61:8'h7A]}) return int'(c) - 97 + 26;
		if (c inside {[8'h30:8'h39]}) return int'(c) - 48 + 52;
		if (c == 8'h2B) return 62;
		if (c == 8'h2F) return 63;
		return -1;
	endfunction

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		if (v < 26) return 8'h41 + 8'(v);
		if (v < 52) return 8'h61 + 8'(v - 26);
		if (v < 62) return 8'h30 + 8'(v - 52);
		return (v == 62) ? 8'h2B : 8'h2F;
	endfunction

	function automatic logic [7:0] blank_pick();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? 8'h20 : 8'(9 + k);
	endfunction

	function automatic b64d_res_t make_res(input logic k, input logic [7:0] b,
			input logic [1:0] st, input logic [15:0] cnt, input logic lst);
		b64d_res_t r;
		r.kind = k;
		r.out_byte = b;
		r.status = st;
		r.byte_count = cnt;
		r.last = lst;
		return r;
	endfunction

	task automatic clear_text_state();
		quad_pos = '0;
		held = '0;
		pad_seen = 1'b0;
		pad_done = 1'b0;
		bad_seen = 1'b0;
		text_started = 1'b0;
		blank_len = '0;
		text_len = '0;
		byte_total = '0;
	endtask

	task automatic predict_decode(input b64d_item_t w);
		int          v;
		int          len_i;
		logic        live;
		logic        emit;
		logic [7:0]  b;
		logic [16:0] len;
		logic [1:0]  st;
		logic [15:0] cnt;
		v = alpha_value(w.ch);
		emit = 1'b0;
		b = 8'h00;
		if (w.present) begin
			if (blank_char(w.ch)) begin
				if (text_started && blank_len != 16'hFFFF) blank_len++;
			end else begin
				live = !pad_done && !bad_seen;
				len = text_started ? {1'b0, text_len} + {1'b0, blank_len} + 17'd1 : 17'd1;
				if (len > 17'h0FFFF) len = 17'h0FFFF;
				text_started = 1'b1;
				if (live && blank_len != 0) begin
					bad_seen = 1'b1;
					live = 1'b0;
				end
				blank_len = '0;
				text_len = len[15:0];
				if (live) begin
					case (quad_pos)
						2'd0: begin
							if (v < 0) bad_seen = 1'b1;
							else begin
								held = v[5:0];
								quad_pos = 2'd1;
							end
						end
						2'd1: begin
							if (v < 0) bad_seen = 1'b1;
							else begin
								b = {held, v[5:4]};
								held = v[5:0];
								quad_pos = 2'd2;
								emit = 1'b1;
							end
						end
						2'd2: begin
							if (w.ch == PAD_CHAR) begin
								pad_seen = 1'b1;
								quad_pos = 2'd3;
							end else if (v < 0) bad_seen = 1'b1;
							else begin
								b = {held[3:0], v[5:2]};
								held = v[5:0];
								quad_pos = 2'd3;
								emit = 1'b1;
							end
						end
						default: begin
							if (pad_seen) begin
								if (w.ch == PAD_CHAR) pad_done = 1'b1;
								else bad_seen = 1'b1;
							end else if (w.ch == PAD_CHAR) pad_done = 1'b1;
							else if (v < 0) bad_seen = 1'b1;
							else begin
								b = {held[1:0], v[5:0]};
								quad_pos = 2'd0;
								emit = 1'b1;
							end
						end
					endcase
				end
				if (emit) begin
					due_results.push_back(make_res(KIND_DATA, b, ST_OK, 16'd0, 1'b0));
					if (byte_total != 16'hFFFF) byte_total++;
				end
			end
		end
		if (w.last) begin
			len_i = int'(text_len);
			cnt = 16'd0;
			if (text_len[1:0] != 2'd0) st = ST_LEN;
			else if (len_i / 4 * 3 + 1 > int'(capacity)) st = ST_CAP;
			else if (bad_seen) st = ST_BAD;
			else begin
				st = ST_OK;
				cnt = byte_total;
			end
			due_results.push_back(make_res(KIND_STATUS, 8'h00, st, cnt, 1'b1));
			clear_text_state();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic check_result();
		b64d_res_t want;
		if (due_results.size() == 0) begin
			$error("result word with nothing expected: tuser %0d tdata %h tlast %0d",
				m_tuser, m_tdata, m_tlast);
			errors++;
		end else begin
			want = due_results.pop_front();
			check_field("kind", 32'(want.kind), 32'(m_tuser));
			check_field("out_byte", 32'(want.out_byte), 32'(m_tdata[7:0]));
			check_field("status", 32'(want.status), 32'(m_tdata[9:8]));
			check_field("byte_count", 32'(want.byte_count), 32'(m_tdata[25:10]));
			check_field("tdata pad", 32'd0, 32'(m_tdata[OUT_TDATA_W-1:26]));
			check_field("last_of_run", 32'(want.last), 32'(m_tlast));
			if (want.kind == KIND_STATUS) status_seen[want.status]++;
			else bytes_seen++;
		end
	endtask

	function automatic logic sender_gap();
		if (idle_mode == IDLE_SENDER) return $urandom_range(0, 99) < 69;
		if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 10;
		return 1'b0;
	endfunction

	function automatic logic receiver_gap();
		if (idle_mode == IDLE_RECEIVER) return $urandom_range(0, 99) < 69;
		if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 10;
		return 1'b0;
	endfunction

	// model and scoreboard
	always @(posedge clk) begin
		word_taken = arst_n && s_tvalid && s_tready;
		if (word_taken) predict_decode('{present: s_tuser, ch: s_tdata, last: s_tlast});
		if (arst_n && m_tvalid && m_tready) check_result();
	end

	// input word driver
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || word_taken)) begin
			if (text_words.size() != 0 && !sender_gap()) begin
				cur_word = text_words.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= cur_word.present;
				s_tdata <= cur_word.ch;
				s_tlast <= cur_word.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output backpressure
	always @(negedge clk) begin
		if (hold_go && hold_cnt < HOLD_CYCLES) begin
			hold_cnt <= hold_cnt + 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !receiver_gap();
		end
	end

	task automatic queue_word(input logic present, input logic [7:0] ch, input logic lst);
		text_words.push_back('{present: present, ch: ch, last: lst});
		if (present || lst) planned_words++;
	endtask

	task automatic queue_text(input string s, input logic last_on_end);
		for (int i = 0; i < s.len(); i++)
			queue_word(1'b1, s[i], last_on_end && i == s.len() - 1);
	endtask

	task automatic queue_message(input int max_bytes);
		logic [7:0]  txt[$];
		logic [31:0] r;
		int          nb;
		int          pos;
		nb = $urandom_range(0, max_bytes);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) txt.push_back(blank_pick());
		for (int i = 0; i < nb; i += 3) begin
			r = $urandom;
			txt.push_back(b64_char(r[7:2]));
			txt.push_back(b64_char({r[1:0], r[15:12]}));
			txt.push_back(nb - i > 1 ? b64_char({r[11:8], r[23:22]}) : PAD_CHAR);
			txt.push_back(nb - i > 2 ? b64_char(r[21:16]) : PAD_CHAR);
		end
		if (txt.size() != 0 && $urandom_range(0, 3) == 0) begin
			pos = $urandom_range(0, txt.size() - 1);
			case ($urandom_range(0, 4))
				0: txt[pos] = 8'($urandom_range(0, 255));
				1: txt.insert(pos, blank_pick());
				2: txt.delete(pos);
				3: repeat ($urandom_range(1, 4))
					txt.push_back($urandom_range(0, 2) == 0 ? PAD_CHAR
						: b64_char(6'($urandom_range(0, 63))));
				default: txt[pos] = PAD_CHAR;
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) txt.push_back(blank_pick());
		for (int i = 0; i < txt.size(); i++) begin
			if ($urandom_range(0, 15) == 0) queue_word(1'b0, 8'($urandom_range(0, 255)), 1'b0);
			queue_word(1'b1, txt[i], i == txt.size() - 1 && $urandom_range(0, 2) != 0);
		end
		if (txt.size() == 0 || !text_words[$].last)
			queue_word(1'b0, 8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic queue_phase(input int max_bytes);
		int goal;
		goal = planned_words + PHASE_WORDS;
		while (planned_words < goal) queue_message(max_bytes);
	endtask

	task automatic wait_idle();
		while (text_words.size() != 0 || s_tvalid) @(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [16:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		capacity = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		#(LIMIT_CYCLES * 2 * HALF_PERIOD);
		$display("FAIL base64_stream_decoder");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: leading blanks, padding, bad pads, inner blank, extremes
		queue_text(" \tTWFu", 1'b1);
		queue_text("QQ== ", 1'b0);
		queue_word(1'b0, 8'h00, 1'b1);
		queue_text("QU=A", 1'b1);
		queue_text("=AAA", 1'b1);
		queue_text("AB C", 1'b1);
		queue_word(1'b0, 8'h00, 1'b0);
		queue_word(1'b1, 8'hFF, 1'b1);
		queue_text("QUI=QQ", 1'b1);
		queue_phase(12);
		wait_idle();

		write_capacity(17'd1);
		idle_mode = IDLE_SENDER;
		queue_phase(12);
		wait_idle();

		write_capacity(17'd13);
		idle_mode = IDLE_RECEIVER;
		queue_phase(15);
		wait_idle();

		write_capacity(17'd65536);
		idle_mode = IDLE_BOTH;
		queue_phase(30);
		wait_idle();

		// output held off while input keeps coming
		write_capacity(17'd100);
		idle_mode = IDLE_NONE;
		queue_phase(12);
		hold_go = 1'b1;
		wait_idle();

		if (due_results.size() != 0) begin
			$error("%0d expected results never arrived", due_results.size());
			errors++;
		end
		$display("covered %0d data bytes and %0d messages over five capacity and idle settings",
			bytes_seen, status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3]);
		$display("status ok %0d, bad char %0d, bad length %0d, capacity short %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (errors == 0) begin
			$display("PASS base64_stream_decoder");
		end else begin
			$display("FAIL base64_stream_decoder");
		end
		$finish;
	end

endmodule
